[hdl/i2cptr_pkg.sv]
// Package for the I2C target register-pointer block.
// Holds the command and phase codes, status bit positions, item and state
// structs, and the index wrap helpers. No dependencies.
package i2cptr_pkg;

    // Size of the register map that the index wraps at (2 to 65536).
    localparam int unsigned MAP_SIZE = 1024;

    localparam logic [16:0] MAP_SIZE_W  = 17'(MAP_SIZE);
    localparam logic [15:0] MAP_LAST_IX = 16'(MAP_SIZE - 1);

    // Bus event codes.
    typedef enum logic [2:0] {
        CMD_ADDR_MATCH = 3'd0,
        CMD_RX_BYTE    = 3'd1,
        CMD_TX_REQ     = 3'd2,
        CMD_STOP       = 3'd3,
        CMD_ACK_FAIL   = 3'd4,
        CMD_BUS_ERROR  = 3'd5
    } cmd_t;

    // Transfer phase.
    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_READING    = 3'd1,
        PH_WRITE_ADDR = 3'd2,
        PH_FIRST_BYTE = 3'd3,
        PH_WRITING    = 3'd4,
        PH_NACKED     = 3'd5,
        PH_STOPPED    = 3'd6
    } phase_t;

    // Status flag bit positions.
    localparam int ST_GENCALL = 0;
    localparam int ST_RSR     = 1;
    localparam int ST_AF      = 2;
    localparam int ST_BERR    = 3;
    localparam int ST_OVR     = 4;
    localparam int ST_BUSY    = 5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NACK_WRITES = 2'd0;
    localparam logic [1:0] CFG_PTR_16_BIT  = 2'd1;
    localparam logic [1:0] CFG_PTR_BIG_END = 2'd2;

    typedef struct packed {
        logic nack_writes;
        logic pointer_16_bit;
        logic pointer_big_endian;
    } cfg_t;

    typedef struct packed {
        logic [2:0] command;
        logic       read_direction;
        logic [7:0] rx_byte;
        logic       gencall_match;
        logic       bus_busy;
        logic       misplaced_bit_error;
        logic       overrun_error;
    } item_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] start_index;
        logic [15:0] current_index;
        logic [15:0] write_count;
        logic [15:0] read_count;
        logic [5:0]  status;
        logic        ack;
    } state_t;

    typedef struct packed {
        logic        write_strobe;
        logic [15:0] write_index;
        logic [7:0]  write_byte;
        logic        read_strobe;
        logic [15:0] read_index;
        logic        ack_enable;
        logic [2:0]  phase;
        logic [15:0] bytes_written;
        logic [15:0] bytes_read;
        logic [5:0]  status_flags;
    } result_t;

    // Next index, wrapping to zero at the map size.
    function automatic logic [15:0] idx_next(input logic [15:0] ix);
        logic [16:0] n;
        n = {1'b0, ix} + 17'd1;
        if (n >= MAP_SIZE_W) begin
            return 16'd0;
        end
        return n[15:0];
    endfunction

    // Previous index, zero steps back to the last map entry.
    function automatic logic [15:0] idx_prev(input logic [15:0] ix);
        if (ix == 16'd0) begin
            return MAP_LAST_IX;
        end
        return ix - 16'd1;
    endfunction

endpackage

[hdl/i2cptr_step.sv]
// Next-state and result logic for one bus event of the register-pointer block.
// Purely combinational; depends on i2cptr_pkg.
module i2cptr_step (
    input  i2cptr_pkg::cfg_t    cfg,
    input  i2cptr_pkg::state_t  state,
    input  i2cptr_pkg::item_t   item,
    output i2cptr_pkg::state_t  state_next,
    output i2cptr_pkg::result_t result
);

    logic        wstb;
    logic [15:0] widx;
    logic [7:0]  wbyte;
    logic        rstb;
    logic [15:0] ridx;

    // Event decode and state update.
    always_comb begin
        state_next = state;
        wstb       = 1'b0;
        widx       = 16'd0;
        wbyte      = 8'd0;
        rstb       = 1'b0;
        ridx       = 16'd0;

        case (i2cptr_pkg::cmd_t'(item.command))
            i2cptr_pkg::CMD_ADDR_MATCH: begin
                state_next.ack = 1'b1;
                if (!item.read_direction) begin
                    state_next.phase       = i2cptr_pkg::PH_WRITE_ADDR;
                    state_next.write_count = 16'd0;
                    if (cfg.nack_writes) begin
                        state_next.ack = 1'b0;
                    end
                end else begin
                    rstb                     = 1'b1;
                    ridx                     = state.start_index;
                    state_next.current_index = i2cptr_pkg::idx_next(state.start_index);
                    state_next.phase         = i2cptr_pkg::PH_READING;
                    state_next.read_count    = 16'd0;
                end
                state_next.status[i2cptr_pkg::ST_GENCALL] = item.gencall_match;
                // Repeated start when the bus was already busy before this match.
                state_next.status[i2cptr_pkg::ST_RSR]  = state.status[i2cptr_pkg::ST_BUSY];
                state_next.status[i2cptr_pkg::ST_BUSY] = item.bus_busy;
            end
            i2cptr_pkg::CMD_RX_BYTE: begin
                state_next.ack = 1'b1;
                case (state.phase)
                    i2cptr_pkg::PH_WRITE_ADDR: begin
                        if (cfg.pointer_16_bit) begin
                            state_next.phase       = i2cptr_pkg::PH_FIRST_BYTE;
                            state_next.start_index = cfg.pointer_big_endian ?
                                {item.rx_byte, 8'd0} : {8'd0, item.rx_byte};
                        end else begin
                            state_next.start_index   = {8'd0, item.rx_byte};
                            state_next.current_index = {8'd0, item.rx_byte};
                            state_next.phase         = i2cptr_pkg::PH_WRITING;
                        end
                    end
                    i2cptr_pkg::PH_FIRST_BYTE: begin
                        state_next.start_index = state.start_index |
                            (cfg.pointer_big_endian ?
                                {8'd0, item.rx_byte} : {item.rx_byte, 8'd0});
                        state_next.current_index = state_next.start_index;
                        state_next.phase         = i2cptr_pkg::PH_WRITING;
                    end
                    default: begin
                        // Any other phase: the byte is written at the current index.
                        wstb  = 1'b1;
                        widx  = state.current_index;
                        wbyte = item.rx_byte;
                        state_next.current_index = i2cptr_pkg::idx_next(state.current_index);
                    end
                endcase
                state_next.write_count = state.write_count + 16'd1;
                state_next.status[i2cptr_pkg::ST_BUSY] = item.bus_busy;
            end
            i2cptr_pkg::CMD_TX_REQ: begin
                state_next.ack           = 1'b1;
                rstb                     = 1'b1;
                ridx                     = state.current_index;
                state_next.current_index = i2cptr_pkg::idx_next(state.current_index);
                state_next.read_count    = state.read_count + 16'd1;
                state_next.status[i2cptr_pkg::ST_BUSY] = item.bus_busy;
            end
            i2cptr_pkg::CMD_STOP: begin
                state_next.ack   = 1'b1;
                state_next.phase = i2cptr_pkg::PH_STOPPED;
                state_next.status[i2cptr_pkg::ST_BUSY] = item.bus_busy;
            end
            i2cptr_pkg::CMD_ACK_FAIL: begin
                // The last byte was not taken, so step the pointer back.
                state_next.current_index = i2cptr_pkg::idx_prev(state.current_index);
                state_next.status[i2cptr_pkg::ST_AF]   = 1'b1;
                state_next.status[i2cptr_pkg::ST_BUSY] = 1'b0;
                state_next.phase = i2cptr_pkg::PH_NACKED;
            end
            i2cptr_pkg::CMD_BUS_ERROR: begin
                if (item.misplaced_bit_error) begin
                    state_next.status[i2cptr_pkg::ST_BERR] = 1'b1;
                end
                if (item.overrun_error) begin
                    state_next.status[i2cptr_pkg::ST_OVR] = 1'b1;
                end
                state_next.phase = i2cptr_pkg::PH_STOPPED;
                state_next.status[i2cptr_pkg::ST_BUSY] = item.bus_busy;
            end
            default: begin
                // Unknown event codes leave the state as it is.
                state_next = state;
            end
        endcase
    end

    // Result item shows the requests and the updated state.
    always_comb begin
        result.write_strobe  = wstb;
        result.write_index   = widx;
        result.write_byte    = wbyte;
        result.read_strobe   = rstb;
        result.read_index    = ridx;
        result.ack_enable    = state_next.ack;
        result.phase         = state_next.phase;
        result.bytes_written = state_next.write_count;
        result.bytes_read    = state_next.read_count;
        result.status_flags  = state_next.status;
    end

endmodule

[hdl/i2c_target_register_pointer_fsm.sv]
// Top level of the I2C target register-pointer block: input register, state
// and result register around i2cptr_step. Depends on i2cptr_pkg, i2cptr_step.
//
// Usage:
//   The s_ channel carries one bus event per item: the event code in s_tuser
//   and its details in s_tdata. The m_ channel returns exactly one result item
//   per event, carrying the register map write or read request, the acknowledge
//   setting, the transfer phase, the byte counts and the status flags.
//   The cfg_ port writes nack_writes (index 0), pointer_16_bit (index 1) and
//   pointer_big_endian (index 2) on any cycle where cfg_we is high; other
//   indexes are ignored. Write it only while no items are in flight.
// Throughput:
//   An accepted item is registered in the input stage, then processed by the
//   step logic as it moves into the result register, which drives m_.
//   One item per cycle is sustained while m_tready is high; the pointer state
//   updates as each item moves on, so consecutive events see each other's effect.
// Reset:
//   aresetn (synchronous, active low) empties both stages, returns the phase
//   to idle, clears indexes, counts, status flags and configuration, and sets
//   the acknowledge setting to one.
// Stall:
//   While m_tready is low the result stays registered; one more item is
//   held in the input register, after which s_tready drops.
module i2c_target_register_pointer_fsm (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic        cfg_wdata,
    // Bus event input.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] read_direction, [8:1] rx_byte, [9] gencall_match, [10] bus_busy,
    // [11] misplaced_bit_error, [12] overrun_error, [15:13] zero
    input  logic [15:0] s_tdata,
    // [2:0] command
    input  logic [2:0]  s_tuser,
    // Result output.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] write_strobe, [16:1] write_index, [24:17] write_byte,
    // [25] read_strobe, [41:26] read_index, [42] ack_enable, [45:43] phase,
    // [61:46] bytes_written, [77:62] bytes_read, [83:78] status_flags,
    // [87:84] zero
    output logic [87:0] m_tdata
);

    i2cptr_pkg::cfg_t    cfg_reg;
    i2cptr_pkg::state_t  state_reg;
    i2cptr_pkg::state_t  state_next;
    i2cptr_pkg::item_t   in_item_reg;
    i2cptr_pkg::item_t   in_item;
    i2cptr_pkg::result_t out_result_reg;
    i2cptr_pkg::result_t result;
    logic                in_valid_reg;
    logic                out_valid_reg;
    logic                advance;

    // Unpack the incoming item.
    always_comb begin
        in_item.command             = s_tuser;
        in_item.read_direction      = s_tdata[0];
        in_item.rx_byte             = s_tdata[8:1];
        in_item.gencall_match       = s_tdata[9];
        in_item.bus_busy            = s_tdata[10];
        in_item.misplaced_bit_error = s_tdata[11];
        in_item.overrun_error       = s_tdata[12];
    end

    // Move the held item into the result stage when that stage is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                i2cptr_pkg::CFG_NACK_WRITES: cfg_reg.nack_writes        <= cfg_wdata;
                i2cptr_pkg::CFG_PTR_16_BIT:  cfg_reg.pointer_16_bit     <= cfg_wdata;
                i2cptr_pkg::CFG_PTR_BIG_END: cfg_reg.pointer_big_endian <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= in_item;
        end
    end

    i2cptr_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (result)
    );

    // Pointer state, updated as each item is processed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase:         i2cptr_pkg::PH_IDLE,
                           start_index:   16'd0,
                           current_index: 16'd0,
                           write_count:   16'd0,
                           read_count:    16'd0,
                           status:        6'd0,
                           ack:           1'b1};
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result;
        end
    end

    // Pack the result item.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0,
                       out_result_reg.status_flags,
                       out_result_reg.bytes_read,
                       out_result_reg.bytes_written,
                       out_result_reg.phase,
                       out_result_reg.ack_enable,
                       out_result_reg.read_index,
                       out_result_reg.read_strobe,
                       out_result_reg.write_byte,
                       out_result_reg.write_index,
                       out_result_reg.write_strobe};

endmodule
